// ===== rtl/hcbd_pkg.sv =====
// Package for the chunked body decoder: transfer payload structs,
// parse mode encoding, framing characters and the hex digit decoder.
// No dependencies.
package hcbd_pkg;

  // One received body byte
  typedef struct packed {
    logic [7:0] data_byte;
    logic       burst_last;
  } in_t;

  // One decoded result
  typedef struct packed {
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic       error_seen;
    logic       final_chunk_seen;
    logic       burst_ok;
  } out_t;

  // Parse modes, one-hot
  typedef enum logic [3:0] {
    MODE_SIZE          = 4'b0001,
    MODE_AFTER_SIZE    = 4'b0010,
    MODE_PAYLOAD       = 4'b0100,
    MODE_AFTER_PAYLOAD = 4'b1000
  } mode_t;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  typedef struct packed {
    logic       is_hex;
    logic [3:0] value;
  } hex_t;

  // Decode one ASCII hex digit, either case
  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.is_hex = 1'b0;
    h.value  = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.is_hex = 1'b1;
      h.value  = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      h.is_hex = 1'b1;
      h.value  = c[3:0] + 4'd9;
    end
    return h;
  endfunction

endpackage

// ===== rtl/http_chunked_body_decoder.sv =====
// Top level of the chunked transfer body decoder.
// Depends on hcbd_pkg.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------
//  in_     | input     | in_valid / in_ready  | hcbd_pkg::in_t
//  out_    | output    | out_valid / out_ready| hcbd_pkg::out_t
//
// One byte per cycle sustained while out_ready stays high; each byte gives exactly one
// result, through the input register and then the result register.
// The parse state updates in the same cycle that a byte moves from the input
// register into the result register; a SIZE_BITS wide decrement and
// zero compare set the clock period.
// Reset (rst_n low, synchronous) clears the parse state and both valids.
// When out_ready is low the two registers fill and in_ready falls.
module http_chunked_body_decoder #(
  parameter int SIZE_BITS = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  hcbd_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output hcbd_pkg::out_t out_data
);
  import hcbd_pkg::*;

  // Input register
  logic s1_valid_r, s1_valid_nxt;
  in_t  s1_data_r;

  // Result register
  logic out_valid_r, out_valid_nxt;
  out_t out_data_r, out_data_nxt;

  // Parse state
  mode_t                mode_r, mode_nxt;
  logic                 digit_seen_r, digit_seen_nxt;
  logic [SIZE_BITS-1:0] size_accum_r, size_accum_nxt;
  logic [SIZE_BITS-1:0] bytes_left_r, bytes_left_nxt;
  logic                 cr_seen_r, cr_seen_nxt;
  logic                 error_flag_r, error_flag_nxt;
  logic                 zero_chunk_r, zero_chunk_nxt;

  logic                 advance, in_xfer, step;
  mode_t                mode_eff;
  logic                 cr_eff;
  logic [7:0]           c;
  hex_t                 hx;
  logic [SIZE_BITS-1:0] bytes_dec;
  logic                 is_payload;

  // Pipeline flow control
  assign advance   = !out_valid_r || out_ready;
  assign in_ready  = !s1_valid_r || advance;
  assign in_xfer   = in_valid && in_ready;
  assign step      = s1_valid_r && advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Byte decode and next parse state
  always_comb begin
    c         = s1_data_r.data_byte;
    hx        = hex_decode(c);
    bytes_dec = bytes_left_r - {{(SIZE_BITS-1){1'b0}}, 1'b1};

    // payload mode with nothing left counts as after payload
    if (mode_r == MODE_PAYLOAD && bytes_left_r == '0) begin
      mode_eff = MODE_AFTER_PAYLOAD;
      cr_eff   = 1'b0;
    end else begin
      mode_eff = mode_r;
      cr_eff   = cr_seen_r;
    end

    mode_nxt       = mode_eff;
    cr_seen_nxt    = cr_eff;
    digit_seen_nxt = digit_seen_r;
    size_accum_nxt = size_accum_r;
    bytes_left_nxt = bytes_left_r;
    error_flag_nxt = error_flag_r;
    zero_chunk_nxt = zero_chunk_r;
    is_payload     = 1'b0;

    if (!error_flag_r) begin
      case (mode_eff)
        MODE_SIZE: begin
          if (hx.is_hex) begin
            if (size_accum_r[SIZE_BITS-1 -: 4] != 4'd0) begin
              error_flag_nxt = 1'b1;
            end else begin
              size_accum_nxt = {size_accum_r[SIZE_BITS-5:0], hx.value};
              digit_seen_nxt = 1'b1;
            end
          end else if (c == CHAR_CR && digit_seen_r) begin
            bytes_left_nxt = size_accum_r;
            if (size_accum_r == '0) begin
              zero_chunk_nxt = 1'b1;
            end
            size_accum_nxt = '0;
            digit_seen_nxt = 1'b0;
            mode_nxt       = MODE_AFTER_SIZE;
          end else begin
            error_flag_nxt = 1'b1;
          end
        end
        MODE_AFTER_SIZE: begin
          if (c == CHAR_LF) begin
            if (bytes_left_r == '0) begin
              mode_nxt    = MODE_AFTER_PAYLOAD;
              cr_seen_nxt = 1'b0;
            end else begin
              mode_nxt = MODE_PAYLOAD;
            end
          end else begin
            error_flag_nxt = 1'b1;
          end
        end
        MODE_PAYLOAD: begin
          bytes_left_nxt = bytes_dec;
          is_payload     = 1'b1;
          if (bytes_dec == '0) begin
            mode_nxt    = MODE_AFTER_PAYLOAD;
            cr_seen_nxt = 1'b0;
          end
        end
        MODE_AFTER_PAYLOAD: begin
          if (!cr_eff) begin
            if (c == CHAR_CR) begin
              cr_seen_nxt = 1'b1;
            end else begin
              error_flag_nxt = 1'b1;
            end
          end else if (c == CHAR_LF) begin
            cr_seen_nxt = 1'b0;
            mode_nxt    = MODE_SIZE;
          end else begin
            error_flag_nxt = 1'b1;
          end
        end
        default: begin
          error_flag_nxt = 1'b1;
        end
      endcase
    end

    out_data_nxt.payload_byte     = is_payload ? c : 8'd0;
    out_data_nxt.payload_valid    = is_payload;
    out_data_nxt.error_seen       = error_flag_nxt;
    out_data_nxt.final_chunk_seen = zero_chunk_nxt;
    out_data_nxt.burst_ok         = s1_data_r.burst_last && !error_flag_nxt;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      mode_r       <= MODE_SIZE;
      digit_seen_r <= 1'b0;
      size_accum_r <= '0;
      bytes_left_r <= '0;
      cr_seen_r    <= 1'b0;
      error_flag_r <= 1'b0;
      zero_chunk_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (step) begin
        mode_r       <= mode_nxt;
        digit_seen_r <= digit_seen_nxt;
        size_accum_r <= size_accum_nxt;
        bytes_left_r <= bytes_left_nxt;
        cr_seen_r    <= cr_seen_nxt;
        error_flag_r <= error_flag_nxt;
        zero_chunk_r <= zero_chunk_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_data_r <= in_data;
    end
    if (step) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

// ===== rtl/hcbd_checker.sv =====
// Port-level checks for the chunked body decoder, bound to the top level.
// Depends on hcbd_pkg and http_chunked_body_decoder.
module hcbd_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           out_valid,
  input logic           out_ready,
  input hcbd_pkg::out_t out_data
);
  import hcbd_pkg::*;

  logic out_xfer;
  logic err_seen_r, err_seen_nxt;
  logic fin_seen_r, fin_seen_nxt;

  assign out_xfer     = out_valid && out_ready;
  assign err_seen_nxt = err_seen_r || (out_xfer && out_data.error_seen);
  assign fin_seen_nxt = fin_seen_r || (out_xfer && out_data.final_chunk_seen);

  // Remember sticky flags from earlier transfers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_seen_r <= 1'b0;
      fin_seen_r <= 1'b0;
    end else begin
      err_seen_r <= err_seen_nxt;
      fin_seen_r <= fin_seen_nxt;
    end
  end

  // No payload once an error is flagged
  a_payload_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.payload_valid |-> !out_data.error_seen && !err_seen_r)
    else $error("payload delivered with error set");

  // Non-payload results carry a zero byte
  a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.payload_valid |-> out_data.payload_byte == 8'd0)
    else $error("non-payload result with nonzero byte");

  // Burst status agrees with the error flag
  a_burst_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.burst_ok |-> !out_data.error_seen)
    else $error("burst_ok with error set");

  // Sticky flags never drop
  a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.error_seen || !err_seen_r) &&
                  (out_data.final_chunk_seen || !fin_seen_r))
    else $error("sticky flag cleared");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind http_chunked_body_decoder hcbd_checker u_hcbd_checker (.*);

// ===== verif/tb_http_chunked_body_decoder.sv =====
// Self-checking testbench for http_chunked_body_decoder: directed and random
// chunked streams, each result checked against a cycle-free model or typed row.
// Depends on hcbd_pkg and the http_chunked_body_decoder RTL.
module tb_http_chunked_body_decoder;
  import hcbd_pkg::*;

  localparam int SIZE_W      = 32;
  localparam int RAND_ITEMS  = 1750;
  localparam int IDLE_LIMIT  = 2000;
  localparam int DIR_N       = 20;
  localparam int GAP_MAX     = 16;

  // Ways of breaking the framing, used once at the end since errors stick
  typedef enum int {
    ERR_EMPTY_SIZE,
    ERR_BAD_SIZE_CHAR,
    ERR_SIZE_OVERFLOW,
    ERR_NO_LF_AFTER_SIZE,
    ERR_NO_CR_AFTER_PAYLOAD,
    ERR_NO_LF_AFTER_CR
  } frame_err_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       typed;
    out_t       want;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  // Decoder model state, reset values
  mode_t             pm_mode        = MODE_SIZE;
  logic              size_digit_seen = 1'b0;
  logic [SIZE_W-1:0] size_acc       = '0;
  logic [SIZE_W-1:0] chunk_left     = '0;
  logic              trail_cr       = 1'b0;
  logic              err_sticky     = 1'b0;
  logic              final_sticky   = 1'b0;

  out_t        decoded_q [$];
  int unsigned bytes_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches   = 0;
  int unsigned idle_cycles  = 0;
  int unsigned rx_gap       = 0;
  bit          res_taken    = 1'b0;
  bit          tx_idle_on   = 1'b1;
  bit          rx_idle_on   = 1'b1;

  dir_row_t dir_rows [DIR_N];

  http_chunked_body_decoder #(.SIZE_BITS(SIZE_W)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Decode one byte, advancing the model state; one result per byte
  function automatic out_t decode_byte(in_t b);
    out_t       r;
    logic [7:0] c;
    logic [3:0] hv;
    logic       is_hex;
    logic       is_pay;
    r      = '0;
    c      = b.data_byte;
    is_pay = 1'b0;
    if (!err_sticky) begin
      if (pm_mode == MODE_PAYLOAD && chunk_left == '0) begin
        pm_mode  = MODE_AFTER_PAYLOAD;
        trail_cr = 1'b0;
      end
      case (pm_mode)
        MODE_SIZE: begin
          is_hex = 1'b1;
          hv     = 4'd0;
          if (c inside {[8'h30:8'h39]}) hv = 4'(c - 8'h30);
          else if (c inside {[8'h41:8'h46]}) hv = 4'(c - 8'h41 + 8'd10);
          else if (c inside {[8'h61:8'h66]}) hv = 4'(c - 8'h61 + 8'd10);
          else is_hex = 1'b0;
          if (is_hex) begin
            // another digit would push bits off the top
            if (size_acc[SIZE_W-1 -: 4] != 4'd0) begin
              err_sticky = 1'b1;
            end else begin
              size_acc        = {size_acc[SIZE_W-5:0], hv};
              size_digit_seen = 1'b1;
            end
          end else if (c == CHAR_CR && size_digit_seen) begin
            chunk_left = size_acc;
            if (size_acc == '0) final_sticky = 1'b1;
            size_acc        = '0;
            size_digit_seen = 1'b0;
            pm_mode         = MODE_AFTER_SIZE;
          end else begin
            err_sticky = 1'b1;
          end
        end
        MODE_AFTER_SIZE: begin
          if (c == CHAR_LF) begin
            if (chunk_left == '0) begin
              pm_mode  = MODE_AFTER_PAYLOAD;
              trail_cr = 1'b0;
            end else begin
              pm_mode = MODE_PAYLOAD;
            end
          end else begin
            err_sticky = 1'b1;
          end
        end
        MODE_PAYLOAD: begin
          chunk_left = chunk_left - 1'b1;
          if (chunk_left == '0) begin
            pm_mode  = MODE_AFTER_PAYLOAD;
            trail_cr = 1'b0;
          end
          is_pay = 1'b1;
        end
        default: begin
          // trailing CRLF of a chunk
          if (!trail_cr) begin
            if (c == CHAR_CR) trail_cr = 1'b1;
            else err_sticky = 1'b1;
          end else if (c == CHAR_LF) begin
            trail_cr = 1'b0;
            pm_mode  = MODE_SIZE;
          end else begin
            err_sticky = 1'b1;
          end
        end
      endcase
    end
    r.payload_byte     = is_pay ? c : 8'h00;
    r.payload_valid    = is_pay;
    r.error_seen       = err_sticky;
    r.final_chunk_seen = final_sticky;
    r.burst_ok         = b.burst_last && !err_sticky;
    return r;
  endfunction

  // Directed row with the result typed in
  function automatic dir_row_t tr(logic [7:0] ch, logic last, logic [7:0] pay, logic pv,
                                  logic err, logic fin, logic ok);
    dir_row_t r;
    r.ch    = ch;
    r.last  = last;
    r.typed = 1'b1;
    r.want  = '{payload_byte: pay, payload_valid: pv, error_seen: err,
                final_chunk_seen: fin, burst_ok: ok};
    return r;
  endfunction

  // Directed row left to the model
  function automatic dir_row_t pr(logic [7:0] ch, logic last);
    dir_row_t r;
    r       = '0;
    r.ch    = ch;
    r.last  = last;
    return r;
  endfunction

  function automatic logic rnd_last();
    return $urandom_range(0, 7) == 0;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH: %s", msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got %0h want %0h", results_seen, name, got,
                                want));
  endtask

  // Send one byte, optionally after an idle gap, and predict its result
  task automatic send_byte(logic [7:0] ch, logic last, logic typed = 1'b0,
                           out_t typed_want = '0);
    int unsigned gap;
    in_t         item;
    out_t        pred;
    item.data_byte  = ch;
    item.burst_last = last;
    gap = tx_idle_on ? $urandom_range(0, GAP_MAX) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = decode_byte(item);
    decoded_q.push_back(typed ? typed_want : pred);
    bytes_sent++;
    if (bytes_sent % 64 == 0) tx_idle_on = 1'($urandom_range(0, 1));
  endtask

  // Stop sending until every predicted result has come back
  task automatic hold_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
  endtask

  // One well-formed chunk: padded hex size of mixed case, CRLF, payload, CRLF
  task automatic send_chunk(int unsigned sz);
    int unsigned n_dig;
    int unsigned lead;
    logic [3:0]  nib;
    logic [7:0]  ch;
    n_dig = 1;
    while (n_dig < 8 && (sz >> (4 * n_dig)) != 0) n_dig++;
    lead = $urandom_range(0, 8 - n_dig);
    repeat (lead) send_byte(8'h30, rnd_last());
    for (int i = n_dig - 1; i >= 0; i--) begin
      nib = 4'(sz >> (4 * i));
      if (nib < 4'd10) ch = 8'h30 + nib;
      else if ($urandom_range(0, 1)) ch = 8'h41 + nib - 8'd10;
      else ch = 8'h61 + nib - 8'd10;
      send_byte(ch, rnd_last());
    end
    send_byte(CHAR_CR, rnd_last());
    send_byte(CHAR_LF, rnd_last());
    repeat (sz) send_byte(8'($urandom_range(0, 255)), rnd_last());
    send_byte(CHAR_CR, rnd_last());
    send_byte(CHAR_LF, rnd_last());
  endtask

  // Receiver: after each transfer, ready may drop for a random stretch
  always @(negedge clk) begin
    if (res_taken) begin
      res_taken = 1'b0;
      rx_gap    = rx_idle_on ? $urandom_range(0, GAP_MAX) : 0;
      if (results_seen % 64 == 0) rx_idle_on = 1'($urandom_range(0, 1));
    end
    if (rx_gap != 0) begin
      out_ready <= 1'b0;
      rx_gap--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Result checker
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      res_taken = 1'b1;
      if (decoded_q.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing pending", results_seen));
      end else begin
        want = decoded_q.pop_front();
        check_field("payload_byte", out_data.payload_byte, want.payload_byte);
        check_field("payload_valid", 8'(out_data.payload_valid), 8'(want.payload_valid));
        check_field("error_seen", 8'(out_data.error_seen), 8'(want.error_seen));
        check_field("final_chunk_seen", 8'(out_data.final_chunk_seen),
                    8'(want.final_chunk_seen));
        check_field("burst_ok", 8'(out_data.burst_ok), 8'(want.burst_ok));
      end
      results_seen++;
    end
  end

  // Watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("http_chunked_body_decoder test failed");
      $finish;
    end
  end

  // Stimulus
  initial begin
    frame_err_t  kind;
    int unsigned sz;
    int unsigned pick;
    logic [7:0]  bad;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;

    // 8-digit size with leading zeros, extreme payload bytes, then a zero chunk
    dir_rows = '{
      tr("0", 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0),
      pr("0", 1'b0), pr("0", 1'b0), pr("0", 1'b0),
      pr("0", 1'b0), pr("0", 1'b0), pr("0", 1'b0),
      tr("3", 1'b1, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1),
      pr(CHAR_CR, 1'b0),
      pr(CHAR_LF, 1'b0),
      tr(8'h00, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0),
      tr(8'hFF, 1'b0, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b0),
      tr(8'h80, 1'b1, 8'h80, 1'b1, 1'b0, 1'b0, 1'b1),
      pr(CHAR_CR, 1'b0),
      pr(CHAR_LF, 1'b0),
      pr("0", 1'b0),
      tr(CHAR_CR, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0),
      pr(CHAR_LF, 1'b0),
      pr(CHAR_CR, 1'b0),
      tr(CHAR_LF, 1'b1, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1)
    };

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_N; i++)
      send_byte(dir_rows[i].ch, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].want);
    hold_until_drained();

    // Random well-formed chunks, mostly short
    while (bytes_sent < RAND_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) sz = 0;
      else if (pick < 90) sz = $urandom_range(1, 16);
      else sz = $urandom_range(17, 255);
      send_chunk(sz);
      if ($urandom_range(0, 29) == 0) hold_until_drained();
    end

    // One framing error to close the stream, then bytes that must be ignored
    kind = frame_err_t'($urandom_range(0, 5));
    case (kind)
      ERR_EMPTY_SIZE: begin
        send_byte(CHAR_CR, rnd_last());
      end
      ERR_BAD_SIZE_CHAR: begin
        do bad = 8'($urandom_range(0, 255));
        while (bad == CHAR_CR || bad inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
        send_byte(bad, rnd_last());
      end
      ERR_SIZE_OVERFLOW: begin
        send_byte("1", rnd_last());
        repeat (8) send_byte("0", rnd_last());
      end
      ERR_NO_LF_AFTER_SIZE: begin
        send_byte("1", rnd_last());
        send_byte(CHAR_CR, rnd_last());
        do bad = 8'($urandom_range(0, 255)); while (bad == CHAR_LF);
        send_byte(bad, rnd_last());
      end
      ERR_NO_CR_AFTER_PAYLOAD: begin
        send_byte("1", rnd_last());
        send_byte(CHAR_CR, rnd_last());
        send_byte(CHAR_LF, rnd_last());
        send_byte(8'($urandom_range(0, 255)), rnd_last());
        do bad = 8'($urandom_range(0, 255)); while (bad == CHAR_CR);
        send_byte(bad, rnd_last());
      end
      default: begin
        send_byte("1", rnd_last());
        send_byte(CHAR_CR, rnd_last());
        send_byte(CHAR_LF, rnd_last());
        send_byte(8'($urandom_range(0, 255)), rnd_last());
        send_byte(CHAR_CR, rnd_last());
        do bad = 8'($urandom_range(0, 255)); while (bad == CHAR_LF);
        send_byte(bad, rnd_last());
      end
    endcase
    repeat (20) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

    hold_until_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && decoded_q.size() == 0) begin
      $display("http_chunked_body_decoder test passed");
    end else begin
      $display("http_chunked_body_decoder test failed");
    end
    $finish;
  end

endmodule

// ===== http_chunked_body_decoder.f =====
rtl/hcbd_pkg.sv
rtl/http_chunked_body_decoder.sv
rtl/hcbd_checker.sv
verif/tb_http_chunked_body_decoder.sv
